// ----- sv/hsl_pkg.sv -----
package hsl_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int SLOTS_MAX = 64;
    localparam int IDX_W = $clog2(SLOTS_MAX);
    localparam int CNT_W = $clog2(SLOTS_MAX + 1);

    localparam logic [31:0] TIMEOUT_RST = 32'd30000;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_ALLOC  = 1'b1;

    typedef struct packed {
        logic             vld;
        logic             req_type;
        logic [31:0]      key;
        logic [31:0]      now_time;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      best;
        logic [IDX_W-1:0] best_idx;
        logic [CNT_W-1:0] expired;
    } token_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [31:0]      key;
        logic [31:0]      now_time;
    } claim_t;

endpackage

// ----- sv/handle_slot_table_lru_expiry.sv -----
// Slot table with lookup and allocate requests, least-recently-used eviction and an idle
// timeout. Each slot lives in a cell of a chain; a request travels down the chain one cell
// per cycle, and its result is registered as it leaves the last cell. The next item is
// accepted only after that result is registered, so one item is in flight at a time.
// Allocate claims the chosen slot as the request leaves the last cell. idle_timeout may be
// written only while no item is in flight.
module handle_slot_table_lru_expiry #(
    parameter int SLOTS = hsl_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [31:0] key,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [2:0]  slot,
    output logic        evicted,
    output logic [3:0]  expired_count
);

    logic [31:0]     idle_timeout_reg;
    logic            busy_reg;
    logic            busy_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            hit_reg;
    logic [2:0]      slot_reg;
    logic            evicted_reg;
    logic [3:0]      expired_reg;

    hsl_pkg::token_t chain [SLOTS+1];
    hsl_pkg::token_t last;
    hsl_pkg::claim_t claim;
    logic            accept;
    logic            finish;
    logic            hold;
    logic            is_alloc;
    logic [hsl_pkg::IDX_W-1:0] pick;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        chain[0].vld      = accept;
        chain[0].req_type = req_type;
        chain[0].key      = key;
        chain[0].now_time = now_time;
        chain[0].found    = 1'b0;
        chain[0].idx      = '0;
        chain[0].best     = now_time;
        chain[0].best_idx = '0;
        chain[0].expired  = '0;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        hsl_cell #(
            .IDX(i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .hold        (hold),
            .idle_timeout(idle_timeout_reg),
            .tok_in      (chain[i]),
            .claim       (claim),
            .tok_out     (chain[i+1])
        );
    end

    assign last     = chain[SLOTS];
    assign finish   = last.vld && (!out_valid_reg || out_ready);
    assign hold     = last.vld && !finish;
    assign is_alloc = (last.req_type == hsl_pkg::REQ_ALLOC);
    assign pick     = last.found ? last.idx : last.best_idx;

    always_comb
    begin
        claim.en       = finish && is_alloc;
        claim.idx      = pick;
        claim.key      = last.key;
        claim.now_time = last.now_time;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= hsl_pkg::TIMEOUT_RST;
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                idle_timeout_reg <= cfg_wr_data;
            end
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            hit_reg     <= !is_alloc && last.found;
            slot_reg    <= is_alloc ? pick[2:0] : last.idx[2:0];
            evicted_reg <= is_alloc && !last.found;
            expired_reg <= is_alloc ? last.expired[3:0] : 4'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted       = evicted_reg;
    assign expired_count = expired_reg;

endmodule

// ----- sv/hsl_cell.sv -----
module hsl_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hold,
    input  logic [31:0]     idle_timeout,
    input  hsl_pkg::token_t tok_in,
    input  hsl_pkg::claim_t claim,
    output hsl_pkg::token_t tok_out
);

    localparam logic [hsl_pkg::IDX_W-1:0] MY_IDX = hsl_pkg::IDX_W'(IDX);

    logic            valid_reg;
    logic            valid_next;
    logic [31:0]     key_reg;
    logic [31:0]     key_next;
    logic [31:0]     time_reg;
    logic [31:0]     time_next;
    hsl_pkg::token_t tok_reg;
    hsl_pkg::token_t tok_next;

    logic            live;
    logic [31:0]     idle;

    assign idle = tok_in.now_time - time_reg;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        time_next  = time_reg;
        live       = valid_reg;
        if (tok_in.vld)
        begin
            if (tok_in.req_type == hsl_pkg::REQ_LOOKUP)
            begin
                if (!tok_in.found && valid_reg && (key_reg == tok_in.key))
                begin
                    tok_next.found = 1'b1;
                    tok_next.idx   = MY_IDX;
                    time_next      = tok_in.now_time;
                end
            end
            else
            begin
                // timeout first, then first free, then running minimum of times
                if (valid_reg && (idle > idle_timeout))
                begin
                    valid_next       = 1'b0;
                    live             = 1'b0;
                    tok_next.expired = tok_in.expired + 1'b1;
                end
                if (!live && !tok_in.found)
                begin
                    tok_next.found = 1'b1;
                    tok_next.idx   = MY_IDX;
                end
                if (time_reg < tok_in.best)
                begin
                    tok_next.best     = time_reg;
                    tok_next.best_idx = MY_IDX;
                end
            end
        end
        if (claim.en && (claim.idx == MY_IDX))
        begin
            valid_next = 1'b1;
            key_next   = claim.key;
            time_next  = claim.now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            time_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            time_reg  <= time_next;
            if (!hold)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- sv/hsl_check.sv -----
module hsl_check #(
    parameter int SLOTS = hsl_pkg::SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [2:0]  slot,
    input logic        evicted,
    input logic [3:0]  expired_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(hit))
        else $error("result dropped while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted && (expired_count == 4'd0))
        else $error("lookup hit carries allocate status");

    a_evict_no_expire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> (expired_count == 4'd0))
        else $error("eviction after a slot was freed by timeout");

    a_expire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SLOTS > 15) || (32'(expired_count) <= 32'(SLOTS)))
        else $error("more slots expired than exist");

endmodule

bind handle_slot_table_lru_expiry hsl_check #(.SLOTS(SLOTS)) u_hsl_check (.*);
